[hdl/tttt_pkg.sv]
package tttt_pkg;

    localparam int TASK_SLOTS_DEFAULT = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam int REQ_W    = 2;
    localparam int TASK_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int STATE_W  = 8;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic ONESHOOT = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]    op;
        logic [TASK_W-1:0]   task_id;
        logic [PERIOD_W-1:0] period_ticks;
        logic                one_shot;
        logic [STATE_W-1:0]  run_state;
        logic [STATE_W-1:0]  new_system_state;
    } cmd_t;

    typedef struct packed {
        logic [TASK_W-1:0]   task_id;
        logic [PERIOD_W-1:0] period;
        logic                one_shot;
        logic [STATE_W-1:0]  run_state;
        logic [PERIOD_W-1:0] elapsed;
    } entry_t;

endpackage

[hdl/tttt_req_if.sv]
interface tttt_req_if
    import tttt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TASK_W-1:0]   task_id;
    logic [PERIOD_W-1:0] period_ticks;
    logic                one_shot;
    logic [STATE_W-1:0]  run_state;
    logic [STATE_W-1:0]  new_system_state;

    modport source (
        output valid, req_type, task_id, period_ticks, one_shot, run_state,
               new_system_state,
        input  ready
    );

    modport sink (
        input  valid, req_type, task_id, period_ticks, one_shot, run_state,
               new_system_state,
        output ready
    );
endinterface

[hdl/tttt_res_if.sv]
interface tttt_res_if
    import tttt_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                fired;
    logic [TASK_W-1:0]   fired_task;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (
        output valid, fired, fired_task, status, last,
        input  ready
    );

    modport sink (
        input  valid, fired, fired_task, status, last,
        output ready
    );
endinterface

[hdl/tttt_front.sv]
module tttt_front
    import tttt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tttt_req_if.sink   req,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_t       cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    // Keep only the fields the request type uses; clear the rest.
    always_comb
    begin
        cmd_next    = '0;
        cmd_next.op = req.req_type;
        case (req.req_type)
            REQ_ADD:
            begin
                cmd_next.task_id      = req.task_id;
                cmd_next.period_ticks = req.period_ticks;
                cmd_next.one_shot     = req.one_shot;
                cmd_next.run_state    = req.run_state;
            end
            REQ_REMOVE:
            begin
                cmd_next.task_id = req.task_id;
            end
            REQ_SET:
            begin
                cmd_next.new_system_state = req.new_system_state;
            end
            default:
            begin
                cmd_next.op = REQ_TICK;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

[hdl/tttt_queue.sv]
module tttt_queue
    import tttt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              push;
    logic              pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/tttt_back.sv]
module tttt_back
    import tttt_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    tttt_res_if.source res
);

    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_FINAL = 2'd3;

    entry_t mem [TASK_SLOTS];
    entry_t rd_a_reg;
    entry_t rd_b_reg;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    entry_count_reg;
    logic [CNT_W-1:0]    entry_count_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic [STATE_W-1:0]  cur_state_reg;
    logic [STATE_W-1:0]  cur_state_next;
    logic [REQ_W-1:0]    op_reg;
    logic [REQ_W-1:0]    op_next;
    logic [TASK_W-1:0]   id_reg;
    logic [TASK_W-1:0]   id_next;
    logic [STATUS_W-1:0] fin_status_reg;
    logic [STATUS_W-1:0] fin_status_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_fired_reg;
    logic [TASK_W-1:0]   out_task_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;
    logic                out_load;
    logic                load_fired;
    logic [TASK_W-1:0]   load_task;
    logic [STATUS_W-1:0] load_status;
    logic                load_last;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    entry_t              mem_wdata;
    logic                rd_en;
    logic [CNT_W-1:0]    cnt_m1;
    logic [IDX_W-1:0]    last_idx;
    logic [PERIOD_W-1:0] elapsed_inc;
    logic                hit;
    logic                fire;
    logic                can_emit;
    entry_t              new_entry;

    assign cnt_m1      = entry_count_reg - CNT_W'(1);
    assign last_idx    = cnt_m1[IDX_W-1:0];
    assign elapsed_inc = rd_a_reg.elapsed + PERIOD_W'(1);
    assign hit         = (elapsed_inc == rd_a_reg.period);
    assign fire        = hit && (rd_a_reg.run_state == cur_state_reg);
    assign can_emit    = !out_valid_reg || res.ready;
    assign cmd_ready   = (state_reg == S_IDLE);

    always_comb
    begin
        new_entry.task_id   = cmd.task_id;
        new_entry.period    = cmd.period_ticks;
        new_entry.one_shot  = cmd.one_shot;
        new_entry.run_state = cmd.run_state;
        new_entry.elapsed   = '0;
    end

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        idx_next         = idx_reg;
        cur_state_next   = cur_state_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        fin_status_next  = fin_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = idx_reg;
        mem_wdata        = rd_a_reg;
        rd_en            = 1'b0;
        out_load         = 1'b0;
        load_fired       = 1'b0;
        load_task        = '0;
        load_status      = STATUS_OK;
        load_last        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next         = cmd.op;
                    id_next         = cmd.task_id;
                    fin_status_next = STATUS_OK;
                    state_next      = S_FINAL;
                    unique case (cmd.op)
                        REQ_TICK,
                        REQ_REMOVE:
                        begin
                            if (entry_count_reg == '0)
                            begin
                                fin_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                idx_next   = (cmd.op == REQ_TICK) ? '0 : last_idx;
                                state_next = S_READ;
                            end
                        end
                        REQ_ADD:
                        begin
                            if (entry_count_reg == CNT_W'(TASK_SLOTS))
                            begin
                                fin_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we           = 1'b1;
                                mem_waddr        = entry_count_reg[IDX_W-1:0];
                                mem_wdata        = new_entry;
                                entry_count_next = entry_count_reg + CNT_W'(1);
                            end
                        end
                        REQ_SET:
                        begin
                            cur_state_next = cmd.new_system_state;
                        end
                        default:
                        begin
                            fin_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (op_reg == REQ_TICK)
                begin
                    // Hold the entry until the result register frees up.
                    if (!fire || can_emit)
                    begin
                        mem_we = 1'b1;
                        if (fire)
                        begin
                            out_load   = 1'b1;
                            load_fired = 1'b1;
                            load_task  = rd_a_reg.task_id;
                        end
                        if (fire && (rd_a_reg.one_shot == ONESHOOT))
                        begin
                            mem_wdata        = rd_b_reg;
                            entry_count_next = cnt_m1;
                        end
                        else
                        begin
                            mem_wdata.elapsed = hit ? '0 : elapsed_inc;
                        end
                        idx_next = idx_reg + 1'b1;
                        if ((CNT_W'(idx_reg) + CNT_W'(1)) < entry_count_next)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_FINAL;
                        end
                    end
                end
                else
                begin
                    // Swap the then-last entry over every match, walking down.
                    if (rd_a_reg.task_id == id_reg)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata        = rd_b_reg;
                        entry_count_next = cnt_m1;
                    end
                    if (idx_reg == '0)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_FINAL:
            begin
                if (can_emit)
                begin
                    out_load    = 1'b1;
                    load_status = fin_status_reg;
                    load_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            cur_state_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            cur_state_reg   <= cur_state_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        id_reg         <= id_next;
        fin_status_reg <= fin_status_next;
        if (out_load)
        begin
            out_fired_reg  <= load_fired;
            out_task_reg   <= load_task;
            out_status_reg <= load_status;
            out_last_reg   <= load_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[idx_reg];
            rd_b_reg <= mem[last_idx];
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.fired      = out_fired_reg;
    assign res.fired_task = out_task_reg;
    assign res.status     = out_status_reg;
    assign res.last       = out_last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(entry_count_reg) <= TASK_SLOTS)
        else $error("entry count above table size");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(entry_count_reg) <= int'($past(entry_count_reg)) + 1) &&
        (int'(entry_count_reg) >= int'($past(entry_count_reg)) - 1))
        else $error("entry count moved by more than one");

    a_exec_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (CNT_W'(idx_reg) < entry_count_reg))
        else $error("walk index outside live entries");

    a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_fired_reg) |-> (!out_last_reg && out_status_reg == STATUS_OK))
        else $error("fired result marked as closing");

    a_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg != S_IDLE))
        else $error("request taken without leaving idle");
`endif

endmodule

[hdl/tick_task_timer_table.sv]
// Set, add and empty-table requests pass the input stage and queue; the sequencer's final state
// then loads the result. Tick: each live entry is read, then updated; fired results leave in
// table order as the walk reaches them. Remove: each entry read, then updated, last first.
// Throughput: one request in flight in the sequencer; a 2-entry queue and an input stage
// keep accepting while it works, and the result register stalls the walk only on backpressure.
// Reset: asynchronous, active low; clears entry count, current state and all handshake state.
module tick_task_timer_table
    import tttt_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    tttt_req_if.sink   req,
    tttt_res_if.source res
);

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic back_valid;
    logic back_ready;
    cmd_t back_cmd;

    tttt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tttt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_cmd)
    );

    tttt_back #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res       (res)
    );

endmodule

[dv/timer_table_checker.sv]
module timer_table_checker
    import tttt_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    tttt_req_if  req,
    tttt_res_if  res,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic                fired;
        logic [TASK_W-1:0]   task_id;
        logic [STATUS_W-1:0] status;
        logic                last;
    } outcome_t;

    entry_t             slot_tab [TASK_SLOTS];
    int unsigned        live_n;
    logic [STATE_W-1:0] sys_state;
    outcome_t           due_results [$];

    // Copy the last live entry over slot dst and shrink the table.
    function automatic void pull_last_into(input int unsigned dst);
        slot_tab[dst] = slot_tab[live_n - 1];
        live_n--;
    endfunction

    function automatic void run_timer_request(input cmd_t c);
        int unsigned i;
        case (c.op)
            REQ_TICK:
            begin
                if (live_n == 0)
                begin
                    due_results.push_back('{1'b0, '0, STATUS_EMPTY, 1'b1});
                end
                else
                begin
                    i = 0;
                    while (i < live_n)
                    begin
                        slot_tab[i].elapsed = slot_tab[i].elapsed + 1'b1;
                        if (slot_tab[i].elapsed == slot_tab[i].period)
                        begin
                            slot_tab[i].elapsed = '0;
                            if (slot_tab[i].run_state == sys_state)
                            begin
                                due_results.push_back('{1'b1, slot_tab[i].task_id,
                                                        STATUS_OK, 1'b0});
                                // the entry moved in is skipped on this tick
                                if (slot_tab[i].one_shot == ONESHOOT)
                                    pull_last_into(i);
                            end
                        end
                        i++;
                    end
                    due_results.push_back('{1'b0, '0, STATUS_OK, 1'b1});
                end
            end
            REQ_ADD:
            begin
                if (live_n >= TASK_SLOTS)
                begin
                    due_results.push_back('{1'b0, '0, STATUS_FULL, 1'b1});
                end
                else
                begin
                    slot_tab[live_n].task_id   = c.task_id;
                    slot_tab[live_n].period    = c.period_ticks;
                    slot_tab[live_n].one_shot  = c.one_shot;
                    slot_tab[live_n].run_state = c.run_state;
                    slot_tab[live_n].elapsed   = '0;
                    live_n++;
                    due_results.push_back('{1'b0, '0, STATUS_OK, 1'b1});
                end
            end
            REQ_REMOVE:
            begin
                if (live_n == 0)
                begin
                    due_results.push_back('{1'b0, '0, STATUS_EMPTY, 1'b1});
                end
                else
                begin
                    i = live_n;
                    while (i > 0)
                    begin
                        i--;
                        if (i < live_n && slot_tab[i].task_id == c.task_id)
                            pull_last_into(i);
                    end
                    due_results.push_back('{1'b0, '0, STATUS_OK, 1'b1});
                end
            end
            default:
            begin
                sys_state = c.new_system_state;
                due_results.push_back('{1'b0, '0, STATUS_OK, 1'b1});
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            live_n     = 0;
            sys_state  = '0;
            due_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                run_timer_request('{req.req_type, req.task_id, req.period_ticks,
                                    req.one_shot, req.run_state, req.new_system_state});
            if (res.valid && res.ready)
            begin
                got = '{res.fired, res.fired_task, res.status, res.last};
                if (due_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transaction: fired=%0b task=%0d status=%0d last=%0b",
                                 got.fired, got.task_id, got.status, got.last);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("result mismatch: expected fired=%0b task=%0d status=%0d last=%0b, got fired=%0b task=%0d status=%0d last=%0b",
                                     want.fired, want.task_id, want.status, want.last,
                                     got.fired, got.task_id, got.status, got.last);
                        fail_count++;
                    end
                end
            end
            pending = due_results.size();
        end
    end

endmodule

[dv/tb_top.sv]
module tb_top;
    import tttt_pkg::*;

    localparam int IDLE_LIMIT = 3000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   burst_left = 0;
    int   idle_cycles = 0;
    int   rdy_mode = 0;
    int   rdy_left = 0;
    int   rdy_phase = 0;

    tttt_req_if req_ch ();
    tttt_res_if res_ch ();

    tick_task_timer_table #(
        .TASK_SLOTS (TASK_SLOTS_DEFAULT)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    timer_table_checker #(
        .TASK_SLOTS (TASK_SLOTS_DEFAULT)
    ) chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: switch between stall patterns, picking each pattern and its run length at random.
    always @(posedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(16, 64);
        end
        else
        begin
            rdy_left--;
        end
        rdy_phase++;
        case (rdy_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= (rdy_phase % 9) >= 6;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    function automatic cmd_t mk_req(input logic [REQ_W-1:0] op, input logic [TASK_W-1:0] id,
                                    input logic [PERIOD_W-1:0] period, input logic shot,
                                    input logic [STATE_W-1:0] rstate,
                                    input logic [STATE_W-1:0] nstate);
        return '{op, id, period, shot, rstate, nstate};
    endfunction

    function automatic cmd_t rand_request(input bit filling);
        cmd_t c;
        int   pick;
        c.op               = REQ_W'($urandom);
        c.task_id          = TASK_W'($urandom);
        c.period_ticks     = PERIOD_W'($urandom);
        c.one_shot         = 1'($urandom);
        c.run_state        = STATE_W'($urandom);
        c.new_system_state = STATE_W'($urandom);
        // leave some requests fully random
        if ($urandom_range(0, 99) < 15)
            return c;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            c.op = REQ_TICK;
        else if (pick < (filling ? 75 : 52))
            c.op = REQ_ADD;
        else if (pick < (filling ? 85 : 86))
            c.op = REQ_REMOVE;
        else
            c.op = REQ_SET;
        if ($urandom_range(0, 9) != 0)
            c.task_id = TASK_W'($urandom_range(0, 7));
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c.period_ticks = '0;
        else if (pick > 1)
            c.period_ticks = PERIOD_W'($urandom_range(1, 6));
        if ($urandom_range(0, 7) != 0)
            c.run_state = STATE_W'($urandom_range(0, 2));
        if ($urandom_range(0, 7) != 0)
            c.new_system_state = STATE_W'($urandom_range(0, 2));
        return c;
    endfunction

    // Call at a rising edge; returns at the rising edge that accepted the
    // transaction, or after the gap that follows a burst.
    task automatic send_req(input cmd_t c);
        req_ch.valid            <= 1'b1;
        req_ch.req_type         <= c.op;
        req_ch.task_id          <= c.task_id;
        req_ch.period_ticks     <= c.period_ticks;
        req_ch.one_shot         <= c.one_shot;
        req_ch.run_state        <= c.run_state;
        req_ch.new_system_state <= c.new_system_state;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic drain_requests();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid            <= 1'b0;
        req_ch.req_type         <= REQ_TICK;
        req_ch.task_id          <= '0;
        req_ch.period_ticks     <= '0;
        req_ch.one_shot         <= 1'b0;
        req_ch.run_state        <= '0;
        req_ch.new_system_state <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // empty table cases
        send_req(mk_req(REQ_TICK, 8'h00, 16'd0, 1'b0, 8'h00, 8'h00));
        send_req(mk_req(REQ_REMOVE, 8'h00, 16'd0, 1'b0, 8'h00, 8'h00));
        send_req(mk_req(REQ_ADD, 8'hFF, 16'd1, 1'b1, 8'h00, 8'h00));
        send_req(mk_req(REQ_ADD, 8'h00, 16'd2, 1'b0, 8'h00, 8'h00));
        // one-shot whose state does not match: cleared but kept
        send_req(mk_req(REQ_ADD, 8'h11, 16'd1, 1'b1, 8'hAA, 8'h00));
        send_req(mk_req(REQ_ADD, 8'h22, 16'd0, 1'b1, 8'hFF, 8'h00));
        send_req(mk_req(REQ_ADD, 8'h33, 16'hFFFF, 1'b0, 8'h00, 8'h00));
        send_req(mk_req(REQ_TICK, 8'h00, 16'd0, 1'b0, 8'h00, 8'h00));
        send_req(mk_req(REQ_SET, 8'h00, 16'd0, 1'b0, 8'h00, 8'hAA));
        send_req(mk_req(REQ_TICK, 8'hFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF));
        // fill the table past full, then fire most of it at once
        for (int k = 0; k < 14; k++)
            send_req(mk_req(REQ_ADD, 8'h5A, 16'd1, k[0], 8'hAA, 8'h00));
        send_req(mk_req(REQ_TICK, 8'h00, 16'd0, 1'b0, 8'h00, 8'h00));
        send_req(mk_req(REQ_REMOVE, 8'h5A, 16'd0, 1'b0, 8'h00, 8'h00));
        drain_requests();

        for (int n = 0; n < 355; n++)
        begin
            if (n % 120 == 60)
                drain_requests();
            send_req(rand_request((n / 60) % 2 == 0));
        end
        drain_requests();
        repeat (80) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
